FILE: rtl/core/swsd_pkg.sv
// ----------------------------------------------------------------------------
// swsd_pkg
// Shared constants for the sliding window sum block: command codes,
// register indexes, default sizes, field widths and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package swsd_pkg;

  // Default table sizes
  localparam int unsigned DefNumEntries  = 1024;
  localparam int unsigned DefNumContexts = 2;
  localparam int unsigned DefNumWindows  = 8;

  // Field widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned EntryW   = 10;
  localparam int unsigned CtxReqW  = 1;
  localparam int unsigned AmountW  = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned SlotOutW = 3;
  localparam int unsigned ScanW    = 11;
  localparam int unsigned CfgIdxW  = 1;

  // Command codes
  localparam logic [CmdW-1:0] CMD_ADD     = 2'd0;
  localparam logic [CmdW-1:0] CMD_STREAK  = 2'd1;
  localparam logic [CmdW-1:0] CMD_ADVANCE = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SCAN_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN   = 1'd1;

  // Register reset values
  localparam logic [ScanW-1:0] ScanCountRst = 11'd1024;
  localparam logic [DataW-1:0] CooldownRst  = 32'd16;

endpackage : swsd_pkg

`default_nettype wire

FILE: rtl/core/sliding_window_sum_decay.sv
// ----------------------------------------------------------------------------
// sliding_window_sum_decay
// Per-entry, per-context event counts over a ring of time windows, with a
// running sum per entry and context and cooldown decay on window advance.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its memories and accepts
// no transaction until done; the pass walks all 2^(EW+CW+WW) addresses, where
// EW, CW and WW are the address widths of entry, context and slot (16384
// at the default sizes). Configuration writes are taken at any time, including
// during the clearing pass. One transaction is processed at a time; its
// result goes into an output register, so a new transaction can be taken
// while an earlier result is still stalled. Steps from accept to result, with
// a read of the synchronous memories followed by the write-back where needed:
//   add            accept, read, modify/write, result
//   streak write   accept, write, result
//   unknown cmd    accept, result
//   advance        sweeps min(scan_count, NUM_ENTRIES) * NUM_CONTEXTS
//                  entry/context pairs; each pair is read and then
//                  written back, then the last result is folded.
// Every transaction returns exactly one result. peak_sum is only nonzero
// after an advance. Adds saturate at 2^32-1; so do the underflow and decay
// counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sum_decay #(
  parameter int unsigned NUM_ENTRIES  = swsd_pkg::DefNumEntries,
  parameter int unsigned NUM_CONTEXTS = swsd_pkg::DefNumContexts,
  parameter int unsigned NUM_WINDOWS  = swsd_pkg::DefNumWindows
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration write port
  input  wire                                 cfg_we_i,
  input  wire  [swsd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  [swsd_pkg::DataW-1:0]          cfg_data_i,
  // input channel
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [swsd_pkg::CmdW-1:0]           cmd_i,
  input  wire  [swsd_pkg::EntryW-1:0]         entry_i,
  input  wire  [swsd_pkg::CtxReqW-1:0]        context_req_i,
  input  wire  [swsd_pkg::AmountW-1:0]        amount_i,
  input  wire  [swsd_pkg::DataW-1:0]          streak_value_i,
  // output channel
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [swsd_pkg::DataW-1:0]          peak_sum_o,
  output logic [swsd_pkg::DataW-1:0]          underflow_total_o,
  output logic [swsd_pkg::DataW-1:0]          decay_total_o,
  output logic [swsd_pkg::SlotOutW-1:0]       window_slot_o
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int unsigned EW = (NUM_ENTRIES  > 1) ? $clog2(NUM_ENTRIES)  : 1;
  localparam int unsigned CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int unsigned WW = $clog2(NUM_WINDOWS);
  localparam int unsigned SumAW = EW + CW;        // running sum address
  localparam int unsigned WinAW = EW + CW + WW;   // window count address
  localparam int unsigned LimW  = EW + 1;         // entry limit, holds NUM_ENTRIES
  localparam int unsigned DW    = swsd_pkg::DataW;

  localparam logic [CW-1:0]   LastCtx  = CW'(NUM_CONTEXTS - 1);
  localparam logic [WW-1:0]   LastSlot = WW'(NUM_WINDOWS - 1);
  localparam logic [DW-1:0]   AllOnes  = {DW{1'b1}};
  localparam logic [WinAW-1:0] ClrLast = {WinAW{1'b1}};

  // --------------------------------------------------------------------------
  // Sequencer states
  // --------------------------------------------------------------------------
  localparam logic [3:0] ST_CLEAR   = 4'd0;  // post-reset memory clear
  localparam logic [3:0] ST_IDLE    = 4'd1;  // waiting for a transaction
  localparam logic [3:0] ST_ADD_RD  = 4'd2;  // add: read slot and sum
  localparam logic [3:0] ST_ADD_WR  = 4'd3;  // add: saturate and write back
  localparam logic [3:0] ST_STREAK  = 4'd4;  // streak write
  localparam logic [3:0] ST_ADV_RD  = 4'd5;  // sweep: read slot, sum, streak
  localparam logic [3:0] ST_ADV_WR  = 4'd6;  // sweep: subtract, decay, write
  localparam logic [3:0] ST_ADV_MAX = 4'd7;  // sweep: fold last result
  localparam logic [3:0] ST_DONE    = 4'd8;  // load the output register

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [3:0]                    state_q, state_d;
  logic [WinAW-1:0]              clr_q, clr_d;
  logic [swsd_pkg::ScanW-1:0]    scan_q, scan_d;
  logic [DW-1:0]                 thr_q, thr_d;
  logic [WW-1:0]                 slot_q, slot_d;
  logic [WW-1:0]                 acc_slot_q, acc_slot_d;  // slot being accessed
  logic [EW-1:0]                 e_q, e_d;
  logic [CW-1:0]                 c_q, c_d;
  logic [LimW-1:0]               limit_q, limit_d;
  logic [swsd_pkg::AmountW-1:0]  amount_q, amount_d;
  logic [DW-1:0]                 streak_q, streak_d;
  logic [DW-1:0]                 res_q, res_d;
  logic [DW-1:0]                 best_q, best_d;
  logic [DW-1:0]                 under_q, under_d;
  logic [DW-1:0]                 decay_q, decay_d;
  logic                          out_valid_q, out_valid_d;
  logic [DW-1:0]                 out_max_q, out_max_d;
  logic [DW-1:0]                 out_under_q, out_under_d;
  logic [DW-1:0]                 out_decay_q, out_decay_d;
  logic [swsd_pkg::SlotOutW-1:0] out_slot_q, out_slot_d;

  // --------------------------------------------------------------------------
  // Memories: one read port and one write port each, registered read data
  // --------------------------------------------------------------------------
  logic [DW-1:0] win_mem [2**WinAW];
  logic [DW-1:0] sum_mem [2**SumAW];
  logic [DW-1:0] stk_mem [2**EW];

  logic             rd_en;
  logic             win_we, sum_we, stk_we;
  logic [WinAW-1:0] win_addr;
  logic [SumAW-1:0] sum_addr;
  logic [EW-1:0]    stk_addr;
  logic [DW-1:0]    win_wdata, sum_wdata, stk_wdata;
  logic [DW-1:0]    win_rdata_q, sum_rdata_q, stk_rdata_q;

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_addr] <= win_wdata;
    end
    if (rd_en) begin
      win_rdata_q <= win_mem[win_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    if (rd_en) begin
      sum_rdata_q <= sum_mem[sum_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= stk_wdata;
    end
    if (rd_en) begin
      stk_rdata_q <= stk_mem[stk_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic            in_accept;
  logic            entry_ok, ctx_ok;
  logic [DW:0]     win_add, sum_add;
  logic [DW-1:0]   win_sat, sum_sat;
  logic            under_hit, cool;
  logic [DW-1:0]   diff, res0, res1;
  logic            decay_hit;
  logic            last_e, last_c;
  logic [LimW-1:0] e_plus;
  logic [DW-1:0]   limit_full;
  logic [WW-1:0]   next_slot;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign entry_ok = (DW'(entry_i) < DW'(NUM_ENTRIES));
  assign ctx_ok   = (DW'(context_req_i) < DW'(NUM_CONTEXTS));

  // shared addressing: clear pass uses the clear counter
  assign win_addr = (state_q == ST_CLEAR) ? clr_q : {e_q, c_q, acc_slot_q};
  assign sum_addr = (state_q == ST_CLEAR) ? clr_q[SumAW-1:0] : {e_q, c_q};
  assign stk_addr = (state_q == ST_CLEAR) ? clr_q[EW-1:0] : e_q;

  // add: saturating at 2^32-1
  assign win_add = {1'b0, win_rdata_q} + (DW+1)'(amount_q);
  assign sum_add = {1'b0, sum_rdata_q} + (DW+1)'(amount_q);
  assign win_sat = win_add[DW] ? AllOnes : win_add[DW-1:0];
  assign sum_sat = sum_add[DW] ? AllOnes : sum_add[DW-1:0];

  // advance: age out the slot, clamp at zero, halve if cooling
  assign under_hit = (sum_rdata_q < win_rdata_q);
  assign diff      = sum_rdata_q - win_rdata_q;
  assign res0      = under_hit ? '0 : diff;
  assign cool      = (stk_rdata_q >= thr_q);
  assign decay_hit = cool && (res0 != '0);
  assign res1      = decay_hit ? (res0 >> 1) : res0;

  assign e_plus = LimW'(e_q) + LimW'(1);
  assign last_e = (e_plus == limit_q);
  assign last_c = (c_q == LastCtx);

  assign limit_full = (DW'(scan_q) > DW'(NUM_ENTRIES)) ? DW'(NUM_ENTRIES) : DW'(scan_q);
  assign next_slot  = (slot_q == LastSlot) ? '0 : (slot_q + WW'(1));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    thr_d       = thr_q;
    slot_d      = slot_q;
    acc_slot_d  = acc_slot_q;
    e_d         = e_q;
    c_d         = c_q;
    limit_d     = limit_q;
    amount_d    = amount_q;
    streak_d    = streak_q;
    res_d       = res_q;
    best_d      = best_q;
    under_d     = under_q;
    decay_d     = decay_q;
    out_valid_d = out_valid_q;
    out_max_d   = out_max_q;
    out_under_d = out_under_q;
    out_decay_d = out_decay_q;
    out_slot_d  = out_slot_q;
    rd_en       = 1'b0;
    win_we      = 1'b0;
    sum_we      = 1'b0;
    stk_we      = 1'b0;
    win_wdata   = '0;
    sum_wdata   = '0;
    stk_wdata   = '0;

    // config writes are taken whenever they arrive
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swsd_pkg::CFG_SCAN_COUNT: scan_d = cfg_data_i[swsd_pkg::ScanW-1:0];
        swsd_pkg::CFG_COOLDOWN:   thr_d  = cfg_data_i;
        default: ;
      endcase
    end

    // output register drains independently
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        win_we = 1'b1;
        sum_we = 1'b1;
        stk_we = 1'b1;
        clr_d  = clr_q + WinAW'(1);
        if (clr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          amount_d = amount_i;
          streak_d = streak_value_i;
          e_d      = EW'(entry_i);
          c_d      = CW'(context_req_i);
          best_d   = '0;
          res_d    = '0;
          unique case (cmd_i)
            swsd_pkg::CMD_ADD: begin
              acc_slot_d = slot_q;
              state_d    = (entry_ok && ctx_ok) ? ST_ADD_RD : ST_DONE;
            end
            swsd_pkg::CMD_STREAK: begin
              state_d = entry_ok ? ST_STREAK : ST_DONE;
            end
            swsd_pkg::CMD_ADVANCE: begin
              acc_slot_d = next_slot;
              e_d        = '0;
              c_d        = '0;
              limit_d    = LimW'(limit_full);
              state_d    = (limit_full == '0) ? ST_ADV_MAX : ST_ADV_RD;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_ADD_RD: begin
        rd_en   = 1'b1;
        state_d = ST_ADD_WR;
      end

      ST_ADD_WR: begin
        win_we    = 1'b1;
        sum_we    = 1'b1;
        win_wdata = win_sat;
        sum_wdata = sum_sat;
        state_d   = ST_DONE;
      end

      ST_STREAK: begin
        stk_we    = 1'b1;
        stk_wdata = streak_q;
        state_d   = ST_DONE;
      end

      ST_ADV_RD: begin
        rd_en = 1'b1;
        // fold the previous pair's result into the maximum
        if (res_q > best_q) begin
          best_d = res_q;
        end
        state_d = ST_ADV_WR;
      end

      ST_ADV_WR: begin
        win_we    = 1'b1;
        sum_we    = 1'b1;
        win_wdata = '0;
        sum_wdata = res1;
        res_d     = res1;
        if (under_hit && (under_q != AllOnes)) begin
          under_d = under_q + DW'(1);
        end
        if (decay_hit && (decay_q != AllOnes)) begin
          decay_d = decay_q + DW'(1);
        end
        if (last_c) begin
          c_d = '0;
          e_d = e_q + EW'(1);
        end else begin
          c_d = c_q + CW'(1);
        end
        state_d = (last_c && last_e) ? ST_ADV_MAX : ST_ADV_RD;
      end

      ST_ADV_MAX: begin
        if (res_q > best_q) begin
          best_d = res_q;
        end
        slot_d  = acc_slot_q;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_max_d   = best_q;
          out_under_d = under_q;
          out_decay_d = decay_q;
          out_slot_d  = swsd_pkg::SlotOutW'(slot_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      scan_q      <= swsd_pkg::ScanCountRst;
      thr_q       <= swsd_pkg::CooldownRst;
      slot_q      <= '0;
      under_q     <= '0;
      decay_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      thr_q       <= thr_d;
      slot_q      <= slot_d;
      under_q     <= under_d;
      decay_q     <= decay_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers: no reset needed
  always_ff @(posedge clk_i) begin
    acc_slot_q  <= acc_slot_d;
    e_q         <= e_d;
    c_q         <= c_d;
    limit_q     <= limit_d;
    amount_q    <= amount_d;
    streak_q    <= streak_d;
    res_q       <= res_d;
    best_q      <= best_d;
    out_max_q   <= out_max_d;
    out_under_q <= out_under_d;
    out_decay_q <= out_decay_d;
    out_slot_q  <= out_slot_d;
  end

  assign out_valid_o       = out_valid_q;
  assign peak_sum_o        = out_max_q;
  assign underflow_total_o = out_under_q;
  assign decay_total_o     = out_decay_q;
  assign window_slot_o     = out_slot_q;

endmodule : sliding_window_sum_decay

`default_nettype wire
